// ===== sv/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants, types and controller states of the sliding window median
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int MAX_WINDOW   = 64;
    localparam int CFG_WIDTH    = 7;
    localparam int FILL_WIDTH   = $clog2(MAX_WINDOW + 1);
    localparam int IDX_WIDTH    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AGE_WIDTH    = IDX_WIDTH;
    localparam int GROUP_SIZE   = 8;
    localparam int NUM_GROUPS   = (MAX_WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [AGE_WIDTH-1:0]           age_t;
    typedef logic [IDX_WIDTH-1:0]           idx_t;
    typedef logic [FILL_WIDTH-1:0]          count_t;
    typedef logic [CFG_WIDTH-1:0]           cfg_t;

    // one stored window element
    typedef struct packed {
        logic    valid;
        sample_t value;
        age_t    age;
    } entry_t;

    // what a cell shows its neighbors
    typedef struct packed {
        entry_t entry;
        logic   gt;     // entry sorts after the incoming sample (or is empty)
        logic   del;    // entry is the evicted one or lies right of it
    } link_t;

    // strobes from the controller to the cell row
    typedef struct packed {
        logic clear;
        logic gather;
        logic select;
        logic shift;
        logic full;
    } chain_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_SELECT,
        ST_SHIFT,
        ST_PICK
    } state_t;

endpackage

// ===== sv/sliding_window_median_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// lower median over the most recent window_size signed samples
// ----------------------------------------------------------------------------
// The window is kept sorted in a row of MAX_WINDOW cells, each holding one
// sample and its age. Every accepted word runs through the controller states
// in order: the accept (idle) state, a gather state and a select state that
// find the value of the oldest sample through a two-level registered or tree,
// and a shift state in which every cell takes from itself, a neighbor or the
// new sample, so the oldest sample leaves and the new one lands in order. A
// word that completes a full window adds a pick state that loads the element
// of rank ceil(window_size/2) into the output register, waiting there while
// a result is still held and m_ready is low. A new word is taken only in the
// idle state, so never before the block is through with the previous one.
// The output register lets a new word in while a result is still waiting.
// While filling (fewer than window_size samples) a word gives no result.
// window_size 0 acts as 1 and values above 64 as 64; a write to it empties
// the window at once and must only come while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_median_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  swm_pkg::sample_t      s_sample,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output swm_pkg::sample_t      m_median,
    // window size register
    input  logic                  cfg_wr_en,
    input  swm_pkg::cfg_t         cfg_wr_data
);

    swm_pkg::state_t      state_reg;
    swm_pkg::state_t      state_next;
    swm_pkg::cfg_t        window_reg;
    swm_pkg::cfg_t        window_next;
    swm_pkg::count_t      fill_reg;
    swm_pkg::count_t      fill_next;
    logic                 full_reg;
    logic                 full_next;
    logic                 emit_reg;
    logic                 emit_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    swm_pkg::sample_t     x_reg;
    swm_pkg::sample_t     m_median_reg;

    swm_pkg::count_t      win_eff;
    swm_pkg::count_t      win_less;
    swm_pkg::age_t        evict_age;
    swm_pkg::idx_t        mid_idx;
    swm_pkg::sample_t     mid_value;
    swm_pkg::chain_ctrl_t ctrl;
    logic                 accept;
    logic                 full_now;
    logic                 load_out;

    // effective window: zero acts as one, saturate at the cell count
    always_comb begin
        if (window_reg == '0) begin
            win_eff = swm_pkg::count_t'(1);
        end else if (window_reg > swm_pkg::MAX_WINDOW) begin
            win_eff = swm_pkg::count_t'(swm_pkg::MAX_WINDOW);
        end else begin
            win_eff = swm_pkg::count_t'(window_reg);
        end
        win_less  = win_eff - 1'b1;
        evict_age = swm_pkg::age_t'(win_less);
        mid_idx   = swm_pkg::idx_t'(win_less >> 1);
    end

    assign accept   = s_valid && s_ready;
    assign full_now = (fill_reg >= win_eff);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = swm_pkg::ST_GATHER;
                end
            end
            swm_pkg::ST_GATHER: begin
                state_next = swm_pkg::ST_SELECT;
            end
            swm_pkg::ST_SELECT: begin
                state_next = swm_pkg::ST_SHIFT;
            end
            swm_pkg::ST_SHIFT: begin
                state_next = emit_reg ? swm_pkg::ST_PICK : swm_pkg::ST_IDLE;
            end
            swm_pkg::ST_PICK: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb begin
        s_ready     = 1'b0;
        ctrl.gather = 1'b0;
        ctrl.select = 1'b0;
        ctrl.shift  = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            swm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            swm_pkg::ST_GATHER: begin
                ctrl.gather = 1'b1;
            end
            swm_pkg::ST_SELECT: begin
                ctrl.select = 1'b1;
            end
            swm_pkg::ST_SHIFT: begin
                ctrl.shift = 1'b1;
            end
            swm_pkg::ST_PICK: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        ctrl.clear = cfg_wr_en;
        ctrl.full  = full_reg;
    end

    // fill count, window register and per-word flags
    always_comb begin
        window_next  = window_reg;
        fill_next    = fill_reg;
        full_next    = full_reg;
        emit_next    = emit_reg;
        m_valid_next = m_valid_reg;
        if (cfg_wr_en) begin
            window_next = cfg_wr_data;
            fill_next   = '0;
        end else if (accept) begin
            fill_next = full_now ? fill_reg : fill_reg + 1'b1;
        end
        if (accept) begin
            full_next = full_now;
            emit_next = full_now || (swm_pkg::count_t'(fill_reg + 1'b1) == win_eff);
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swm_pkg::ST_IDLE;
            window_reg  <= swm_pkg::cfg_t'(1);
            fill_reg    <= '0;
            full_reg    <= 1'b0;
            emit_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            window_reg  <= window_next;
            fill_reg    <= fill_next;
            full_reg    <= full_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg <= s_sample;
        end
        if (load_out) begin
            m_median_reg <= mid_value;
        end
    end

    swm_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .sample_x  (x_reg),
        .evict_age (evict_age),
        .mid_idx   (mid_idx),
        .mid_value (mid_value)
    );

    assign m_valid  = m_valid_reg;
    assign m_median = m_median_reg;

endmodule

// ===== sv/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: deletes, shifts and inserts with its neighbors
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swm_pkg::chain_ctrl_t  ctrl,
    input  swm_pkg::sample_t      sample_x,
    input  swm_pkg::sample_t      evict_key,
    input  swm_pkg::age_t         evict_age,
    input  swm_pkg::link_t        left_link,
    input  swm_pkg::link_t        right_link,
    output swm_pkg::link_t        self_link,
    output logic                  evict_hit
);

    logic             valid_reg;
    logic             valid_next;
    swm_pkg::sample_t value_reg;
    swm_pkg::sample_t value_next;
    swm_pkg::age_t    age_reg;
    swm_pkg::age_t    age_next;

    swm_pkg::entry_t  cur;
    swm_pkg::entry_t  d_self;
    swm_pkg::entry_t  d_left;
    logic             gd_self;
    logic             gd_left;
    logic             gt;
    logic             del;

    always_comb begin
        cur.valid = valid_reg;
        cur.value = value_reg;
        cur.age   = age_reg;

        gt        = !valid_reg || (value_reg > sample_x);
        // equal values keep newest to the right, so the oldest is leftmost
        del       = ctrl.full && valid_reg && (value_reg >= evict_key);
        evict_hit = valid_reg && (age_reg == evict_age);

        self_link.entry = cur;
        self_link.gt    = gt;
        self_link.del   = del;
    end

    // view after the eviction: own slot and left slot
    always_comb begin
        d_self  = del ? right_link.entry : cur;
        gd_self = del ? right_link.gt : gt;
        d_left  = left_link.del ? cur : left_link.entry;
        gd_left = left_link.del ? gt : left_link.gt;
    end

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
        end else if (ctrl.shift) begin
            if (gd_self && gd_left) begin
                valid_next = d_left.valid;
                value_next = d_left.value;
                age_next   = d_left.age + 1'b1;
            end else if (gd_self) begin
                valid_next = 1'b1;
                value_next = sample_x;
                age_next   = '0;
            end else begin
                valid_next = d_self.valid;
                value_next = d_self.value;
                age_next   = d_self.age + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

// ===== sv/swm_chain.sv =====
// ----------------------------------------------------------------------------
// swm_chain
// row of window cells with the registered gather tree for the evicted value
// ----------------------------------------------------------------------------
module swm_chain (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swm_pkg::chain_ctrl_t  ctrl,
    input  swm_pkg::sample_t      sample_x,
    input  swm_pkg::age_t         evict_age,
    input  swm_pkg::idx_t         mid_idx,
    output swm_pkg::sample_t      mid_value
);

    swm_pkg::link_t   links [swm_pkg::MAX_WINDOW];
    logic [swm_pkg::MAX_WINDOW-1:0] hit;
    swm_pkg::link_t   bound_left;
    swm_pkg::link_t   bound_right;

    swm_pkg::sample_t group_reg  [swm_pkg::NUM_GROUPS];
    swm_pkg::sample_t group_next [swm_pkg::NUM_GROUPS];
    swm_pkg::sample_t evict_key_reg;
    swm_pkg::sample_t evict_key_next;

    always_comb begin
        bound_left     = '0;
        bound_right    = '0;
        bound_right.gt = 1'b1;
    end

    for (genvar i = 0; i < swm_pkg::MAX_WINDOW; i++) begin : g_cell
        swm_pkg::link_t left_in;
        swm_pkg::link_t right_in;

        if (i == 0) begin : g_first
            assign left_in = bound_left;
        end else begin : g_inner_l
            assign left_in = links[i-1];
        end

        if (i == swm_pkg::MAX_WINDOW - 1) begin : g_last
            assign right_in = bound_right;
        end else begin : g_inner_r
            assign right_in = links[i+1];
        end

        swm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .sample_x   (sample_x),
            .evict_key  (evict_key_reg),
            .evict_age  (evict_age),
            .left_link  (left_in),
            .right_link (right_in),
            .self_link  (links[i]),
            .evict_hit  (hit[i])
        );
    end

    // first tree level: one-hot or within each group
    always_comb begin
        for (int g = 0; g < swm_pkg::NUM_GROUPS; g++) begin
            group_next[g] = '0;
            for (int j = 0; j < swm_pkg::GROUP_SIZE; j++) begin
                if (g * swm_pkg::GROUP_SIZE + j < swm_pkg::MAX_WINDOW) begin
                    if (hit[g * swm_pkg::GROUP_SIZE + j]) begin
                        group_next[g] = group_next[g]
                                      | links[g * swm_pkg::GROUP_SIZE + j].entry.value;
                    end
                end
            end
        end
    end

    always_comb begin
        evict_key_next = '0;
        for (int g = 0; g < swm_pkg::NUM_GROUPS; g++) begin
            evict_key_next = evict_key_next | group_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.gather) begin
            for (int g = 0; g < swm_pkg::NUM_GROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
        if (ctrl.select) begin
            evict_key_reg <= evict_key_next;
        end
    end

    assign mid_value = links[mid_idx].entry.value;

endmodule

// ===== tb/swm_median_scoreboard.sv =====
// ----------------------------------------------------------------------------
// swm_median_scoreboard
// predicts and checks the lower median of the sliding window median unit
// ----------------------------------------------------------------------------
package swm_tb_pkg;

    class median_scoreboard;

        int unsigned      span;               // effective window length
        swm_pkg::sample_t by_arrival[$];      // window, oldest first
        swm_pkg::sample_t by_value[$];        // same window, ascending
        swm_pkg::sample_t pending_medians[$];
        int unsigned      mismatches;

        function new();
            span       = 1;
            mismatches = 0;
        endfunction

        // a write of the size register empties the window
        function void set_window_size(swm_pkg::cfg_t size);
            if (size == 0) begin
                span = 1;
            end else if (size > swm_pkg::MAX_WINDOW) begin
                span = swm_pkg::MAX_WINDOW;
            end else begin
                span = size;
            end
            by_arrival.delete();
            by_value.delete();
        endfunction

        function void note_sample(swm_pkg::sample_t v);
            swm_pkg::sample_t oldest;
            int unsigned      pos;
            while (by_arrival.size() >= span) begin
                oldest = by_arrival.pop_front();
                pos = 0;
                while (by_value[pos] != oldest) pos++;
                by_value.delete(pos);
            end
            pos = 0;
            while (pos < by_value.size() && by_value[pos] <= v) pos++;
            by_value.insert(pos, v);
            by_arrival.push_back(v);
            // lower median once the window is full
            if (by_arrival.size() == span)
                pending_medians.push_back(by_value[(span - 1) / 2]);
        endfunction

        function int unsigned outstanding();
            return pending_medians.size();
        endfunction

        function void check_median(swm_pkg::sample_t got, longint unsigned stamp);
            swm_pkg::sample_t want;
            if (pending_medians.size() == 0) begin
                $display("%0d ns: unexpected median word, expected none, actual %0d",
                         stamp, got);
                mismatches++;
                return;
            end
            want = pending_medians.pop_front();
            if (got !== want) begin
                $display("%0d ns: median mismatch, expected %0d, actual %0d",
                         stamp, want, got);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// ===== tb/tb_sliding_window_median_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_median_unit
// self-checking bench for the sliding window median unit
// ----------------------------------------------------------------------------
// Drives signed sample words through the input channel and compares every
// median word against a scoreboard that keeps the window in arrival order
// and in value order. A short directed run covers the sample extremes,
// window sizes zero, one, two and three and equal values; random phases then
// rewrite the window size (saturating and small sizes included) and stream
// random words with bursts of idle on both channels, calm at the very end.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_WORDS  = 600;
    localparam int unsigned CALM_WORDS    = 60;
    // settle time for a word still inside the block, plus margin
    localparam int unsigned SETTLE_CYCLES = 12;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    swm_pkg::sample_t s_sample    = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    swm_pkg::sample_t m_median;
    logic             cfg_wr_en   = 1'b0;
    swm_pkg::cfg_t    cfg_wr_data = '0;

    swm_tb_pkg::median_scoreboard sb;

    // idle odds per phase, zero means no idling at all
    int unsigned tx_odds = 2;
    int unsigned rx_odds = 2;
    bit          calm    = 1'b0;
    int unsigned rx_hold = 0;

    always #5 aclk = ~aclk;

    sliding_window_median_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_median    (m_median),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // result side: ready mostly high, with random stall bursts
    always @(posedge aclk) begin
        if (calm)
            rx_hold = 0;
        else if (rx_hold == 0 && rx_odds != 0 && $urandom_range(0, rx_odds * 4) == 0)
            rx_hold = $urandom_range(1, 16);
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // every median word taken is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_median(m_median, $time);
    end

    // mix of full-range values, small values that collide, and extremes
    function automatic swm_pkg::sample_t random_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return swm_pkg::sample_t'($urandom);
            5, 6:          return swm_pkg::sample_t'(int'($urandom_range(0, 16)) - 8);
            7:             return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            8:             return s_sample;
            default: begin
                if ($urandom_range(0, 1))
                    return swm_pkg::sample_t'(32'h8000_0000 + $urandom_range(0, 3));
                return swm_pkg::sample_t'(32'h7FFF_FFFF - $urandom_range(0, 3));
            end
        endcase
    endfunction

    // one input word, optionally after an idle burst; valid stays up after
    // acceptance so back-to-back words need no second assignment
    task automatic push_sample(input swm_pkg::sample_t v);
        if (!calm && tx_odds != 0 && $urandom_range(0, tx_odds * 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(v);
    endtask

    // hold off until every predicted median has arrived and the block is quiet
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // size register is only touched with the block idle
    task automatic write_window(input swm_pkg::cfg_t size);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_window_size(size);
    endtask

    initial begin
        swm_pkg::cfg_t setting;
        int unsigned   span;
        int unsigned   sent;
        int unsigned   phase;

        sb = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // window of one after reset: words pass straight through
        push_sample(32'sh8000_0000);
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh0000_0000);
        push_sample(32'shFFFF_FFFF);
        push_sample(32'sh5555_5555);
        push_sample(32'shAAAA_AAAA);

        // size zero acts as one
        write_window(swm_pkg::cfg_t'(0));
        push_sample(32'sh0000_0001);
        push_sample(32'sh8000_0001);

        // size two: lower median is the smaller of the pair
        write_window(swm_pkg::cfg_t'(2));
        push_sample(32'sh7FFF_FFFF);
        push_sample(32'sh8000_0000);
        push_sample(32'sh0000_0003);
        push_sample(32'sh0000_0003);

        // size three with repeated values and both extremes
        write_window(swm_pkg::cfg_t'(3));
        push_sample(32'sh0000_0007);
        push_sample(32'sh0000_0007);
        push_sample(-32'sh0000_0007);
        push_sample(32'sh0000_0007);
        push_sample(32'sh8000_0000);
        push_sample(32'sh7FFF_FFFF);
        push_sample(-32'sh0000_0007);

        // random phases: saturating and full sizes first, then mostly small
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS) begin
            if (sent + CALM_WORDS < RANDOM_WORDS) begin
                case (phase)
                    0: setting = swm_pkg::cfg_t'(127);
                    1: setting = swm_pkg::cfg_t'(swm_pkg::MAX_WINDOW);
                    2: setting = swm_pkg::cfg_t'(1);
                    3: setting = swm_pkg::cfg_t'(0);
                    default: begin
                        if ($urandom_range(0, 3) == 0)
                            setting = swm_pkg::cfg_t'($urandom_range(0, 127));
                        else
                            setting = swm_pkg::cfg_t'($urandom_range(1, 12));
                    end
                endcase
                write_window(setting);
                tx_odds = $urandom_range(0, 3);
                rx_odds = $urandom_range(0, 3);
                span = (setting == 0) ? 1 :
                       (setting > swm_pkg::MAX_WINDOW) ? swm_pkg::MAX_WINDOW : setting;
                span = span + $urandom_range(8, 40);
            end else begin
                // calm tail keeps the current window size
                span = RANDOM_WORDS - sent;
            end
            if (span > RANDOM_WORDS - sent)
                span = RANDOM_WORDS - sent;
            repeat (span) begin
                calm = (sent + CALM_WORDS >= RANDOM_WORDS);
                // now and then let the pipe run dry mid-stream
                if (!calm && $urandom_range(0, 199) == 0)
                    drain();
                push_sample(random_sample());
                sent++;
            end
            phase++;
        end

        drain();
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
